// ===== hdl/assert_macros.svh =====
// assertion macros shared by the frame receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define ASSERT_HOLD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLD(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/frp_pkg.sv =====
// types and constants of the framed packet receiver
`timescale 1ns / 1ps
`default_nettype none
package frp_pkg;

  // payload buffer geometry
  localparam int PAYLOAD_DEPTH = 256;
  localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

  // bytes of frame overhead subtracted from the length byte
  localparam logic [7:0] FRAME_OVERHEAD = 8'd4;

  // command codes
  localparam logic [1:0] CMD_RECV    = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // parser state codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK1  = 3'd4;

  // register indexes on the configuration port
  localparam logic REG_START_PLAIN  = 1'b0;
  localparam logic REG_START_SECURE = 1'b1;

  // reset values of the start byte registers
  localparam logic [7:0] START_PLAIN_RST  = 8'd153;
  localparam logic [7:0] START_SECURE_RST = 8'd152;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       frame_ready;
    logic       frame_good;
    logic       frame_error;
    logic       encrypted;
    logic [7:0] payload_length;
    logic [7:0] error_count;
    logic [7:0] overrun_count;
    logic [2:0] parse_state;
  } out_word_t;

  typedef struct packed {
    logic [7:0] start_plain;
    logic [7:0] start_secure;
  } frp_cfg_t;

  typedef struct packed {
    logic       frame_ready;
    logic       frame_good;
    logic       frame_error;
    logic       encrypted;
    logic [7:0] payload_length;
    logic [7:0] error_count;
    logic [7:0] overrun_count;
    logic [2:0] parse_state;
  } frp_status_t;

  typedef struct packed {
    logic                  en;
    logic [PAYLOAD_AW-1:0] addr;
    logic [7:0]            data;
  } frp_ram_wr_t;

endpackage
`default_nettype wire

// ===== hdl/frp_parser.sv =====
// frame parser: state machine, running checks and error counters
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module frp_parser
  import frp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire in_word_t    word,
  input  wire frp_cfg_t    cfg,
  output frp_status_t      status,
  output frp_ram_wr_t      ram_wr
);

  logic [2:0] phase_r,   phase_nxt;
  logic       secure_r,  secure_nxt;
  logic       ready_r,   ready_nxt;
  logic [7:0] exp_len_r, exp_len_nxt;
  logic [7:0] idx_r,     idx_nxt;
  logic [7:0] sum_a_r,   sum_a_nxt;
  logic [7:0] sum_b_r,   sum_b_nxt;
  logic [7:0] err_cnt_r, err_cnt_nxt;
  logic [7:0] ovr_cnt_r, ovr_cnt_nxt;
  logic       good_r,    good_nxt;
  logic       bad_r,     bad_nxt;
  logic [7:0] c;
  logic [7:0] sum_a_acc;

  assign c         = word.data_byte;
  assign sum_a_acc = sum_a_r + c;

  // next state for one accepted word
  always_comb begin
    phase_nxt   = phase_r;
    secure_nxt  = secure_r;
    ready_nxt   = ready_r;
    exp_len_nxt = exp_len_r;
    idx_nxt     = idx_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    err_cnt_nxt = err_cnt_r;
    ovr_cnt_nxt = ovr_cnt_r;
    good_nxt    = 1'b0;
    bad_nxt     = 1'b0;
    ram_wr.en   = 1'b0;
    ram_wr.addr = idx_r[PAYLOAD_AW-1:0];
    ram_wr.data = c;
    if (word.cmd == CMD_RECV) begin
      unique case (phase_r)
        PH_IDLE: begin
          // plain start wins when both registers match
          if (c == cfg.start_plain) begin
            phase_nxt  = PH_START;
            secure_nxt = 1'b0;
          end else if (c == cfg.start_secure) begin
            phase_nxt  = PH_START;
            secure_nxt = 1'b1;
          end
        end
        PH_START: begin
          if (ready_r) begin
            // length byte while a frame is still held
            ovr_cnt_nxt = ovr_cnt_r + 8'd1;
            err_cnt_nxt = err_cnt_r + 8'd1;
            bad_nxt     = 1'b1;
            phase_nxt   = PH_IDLE;
          end else begin
            exp_len_nxt = c - FRAME_OVERHEAD;
            sum_a_nxt   = c;
            sum_b_nxt   = c;
            idx_nxt     = 8'd0;
            phase_nxt   = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          ram_wr.en = 1'b1;
          sum_a_nxt = sum_a_acc;
          sum_b_nxt = sum_b_r + sum_a_acc;
          idx_nxt   = idx_r + 8'd1;
          if (idx_nxt == exp_len_r) begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (c != sum_a_r) begin
            err_cnt_nxt = err_cnt_r + 8'd1;
            bad_nxt     = 1'b1;
            phase_nxt   = PH_IDLE;
          end else begin
            phase_nxt = PH_CHECK1;
          end
        end
        PH_CHECK1: begin
          if (c != sum_b_r) begin
            err_cnt_nxt = err_cnt_r + 8'd1;
            bad_nxt     = 1'b1;
          end else begin
            ready_nxt = 1'b1;
            good_nxt  = 1'b1;
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
          err_cnt_nxt = err_cnt_r + 8'd1;
          bad_nxt     = 1'b1;
          phase_nxt   = PH_IDLE;
        end
      endcase
    end else if (word.cmd == CMD_RELEASE) begin
      ready_nxt = 1'b0;
    end
    if (!accept) begin
      ram_wr.en = 1'b0;
    end
  end

  // parser registers, updated only on accepted words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      secure_r  <= 1'b0;
      ready_r   <= 1'b0;
      exp_len_r <= 8'd0;
      idx_r     <= 8'd0;
      sum_a_r   <= 8'd0;
      sum_b_r   <= 8'd0;
      err_cnt_r <= 8'd0;
      ovr_cnt_r <= 8'd0;
      good_r    <= 1'b0;
      bad_r     <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      secure_r  <= secure_nxt;
      ready_r   <= ready_nxt;
      exp_len_r <= exp_len_nxt;
      idx_r     <= idx_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      err_cnt_r <= err_cnt_nxt;
      ovr_cnt_r <= ovr_cnt_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
    end
  end

  // status after the last accepted word
  assign status.frame_ready    = ready_r;
  assign status.frame_good     = good_r;
  assign status.frame_error    = bad_r;
  assign status.encrypted      = secure_r;
  assign status.payload_length = exp_len_r;
  assign status.error_count    = err_cnt_r;
  assign status.overrun_count  = ovr_cnt_r;
  assign status.parse_state    = phase_r;

  // a completed frame always leaves the ready flag set and the parser idle
  `ASSERT_HOLD(a_good_sets_ready, clk, rst_n, !good_r || (ready_r && phase_r == PH_IDLE),
               "frame_good without ready flag")
  // a frame cannot be both good and bad
  `ASSERT_HOLD(a_good_bad_excl, clk, rst_n, !(good_r && bad_r), "good and error together")
  // an overrun bumps both counters and returns to idle
  `ASSERT_NEXT(a_overrun_count, clk, rst_n,
               accept && word.cmd == CMD_RECV && phase_r == PH_START && ready_r,
               ovr_cnt_r == $past(ovr_cnt_r) + 8'd1 && err_cnt_r == $past(err_cnt_r) + 8'd1
               && bad_r && phase_r == PH_IDLE,
               "overrun not counted")

endmodule
`default_nettype wire

// ===== hdl/framed_packet_receiver_top.sv =====
// top level of the framed packet receiver
`timescale 1ns / 1ps
`default_nettype none
// Usage
// - in_valid/in_ready/in_data carry one command word: receive a byte, release the
//   held frame, or read a stored payload byte.
// - out_valid/out_ready/out_data return exactly one result word per command word,
//   holding the parser status after that word and, for a read, the payload byte.
// - the result is registered: a word accepted at an edge has its result valid right
//   after that edge, so the result can be taken at the next edge at the earliest.
// - throughput is one word per cycle; the parser state and the 256-byte payload
//   buffer (one write or one read port use per word) update at the accept edge.
// - the result register sits between the channels; in_ready stays high while the
//   result slot is empty or being taken, and drops while out_valid waits on a
//   stalled out_ready, so no result is lost or repeated.
// - psel/penable/pwrite/paddr/pwdata program the two start bytes (offsets 0 and
//   4); pready is tied high and prdata returns the addressed register.
// - reset (rst_n low, synchronous) returns the parser to idle, clears flags and
//   counters and restores the start bytes; the payload buffer is not cleared, so
//   reads may return bytes stored before the reset.
`include "assert_macros.svh"
module framed_packet_receiver_top
  import frp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  frp_cfg_t    cfg_r;
  frp_status_t status;
  frp_ram_wr_t ram_wr;
  logic        accept;
  logic        out_valid_r, out_valid_nxt;
  logic        rd_sel_r;
  logic [7:0]  mem_q_r;
  logic [7:0]  payload_mem [PAYLOAD_DEPTH];
  logic        cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_plain  <= START_PLAIN_RST;
      cfg_r.start_secure <= START_SECURE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_START_PLAIN:  cfg_r.start_plain  <= pwdata[7:0];
        REG_START_SECURE: cfg_r.start_secure <= pwdata[7:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  assign prdata = {24'd0, (paddr[2] == REG_START_SECURE) ? cfg_r.start_secure
                                                           : cfg_r.start_plain};

  // handshake: take a word whenever the result slot frees up
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_sel_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        rd_sel_r <= (in_data.cmd == CMD_READ);
      end
    end
  end

  // frame parser
  frp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .word   (in_data),
    .cfg    (cfg_r),
    .status (status),
    .ram_wr (ram_wr)
  );

  // payload buffer: write from the parser, registered read on read commands
  always_ff @(posedge clk) begin
    if (ram_wr.en) begin
      payload_mem[ram_wr.addr] <= ram_wr.data;
    end
    if (accept && in_data.cmd == CMD_READ) begin
      mem_q_r <= payload_mem[in_data.read_index[PAYLOAD_AW-1:0]];
    end
  end

  // result word
  assign out_valid               = out_valid_r;
  assign out_data.read_data      = rd_sel_r ? mem_q_r : 8'd0;
  assign out_data.frame_ready    = status.frame_ready;
  assign out_data.frame_good     = status.frame_good;
  assign out_data.frame_error    = status.frame_error;
  assign out_data.encrypted      = status.encrypted;
  assign out_data.payload_length = status.payload_length;
  assign out_data.error_count    = status.error_count;
  assign out_data.overrun_count  = status.overrun_count;
  assign out_data.parse_state    = status.parse_state;

  // every accepted word leaves a result waiting
  `ASSERT_NEXT(a_accept_result, clk, rst_n, accept, out_valid_r, "accepted word lost")
  // the parser only writes the buffer on an accepted receive word
  `ASSERT_HOLD(a_write_on_recv, clk, rst_n, !ram_wr.en || (accept && in_data.cmd == CMD_RECV),
               "payload write without receive")
  // check flags only follow a receive word
  `ASSERT_HOLD(a_flags_recv, clk, rst_n,
               !(rd_sel_r && (status.frame_good || status.frame_error)),
               "check flag on read word")

endmodule
`default_nettype wire
